@@ hw/rtl/bba_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Widths, codes and the control state type shared by the allocator files.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int MAP_WORD_BITS = 64;
    localparam int BIT_W         = 6;
    localparam int ADDR_W        = 32;
    localparam int COUNT_W       = 11;
    localparam int SIZE_W        = 17;
    localparam int UNITS_W       = 12;
    localparam int INDEX_OUT_W   = 10;
    localparam int STATUS_W      = 2;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 32;
    localparam int OFFSET_W      = ADDR_W - BIT_W;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OUTSIDE = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_COUNT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_SIZE   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_ADDRESS = 2'd2;

    localparam logic [COUNT_W-1:0] BLOCK_COUNT_RESET  = 11'd1024;
    localparam logic [SIZE_W-1:0]  BLOCK_SIZE_RESET   = 17'd64;
    localparam logic [ADDR_W-1:0]  BASE_ADDRESS_RESET = 32'd0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRAP,
        ST_SCAN_RD,
        ST_SCAN_EVAL,
        ST_MUL,
        ST_ADD,
        ST_DIV,
        ST_FREE_RD,
        ST_FREE_WR,
        ST_RESULT
    } bba_state_t;

endpackage

@@ hw/rtl/bba_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator channels
// Request, response and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface bba_req_if;
    import bba_pkg::*;

    logic              valid;
    logic              ready;
    logic              op;
    logic [ADDR_W-1:0] free_address;

    modport source (output valid, op, free_address, input ready);
    modport sink (input valid, op, free_address, output ready);
endinterface

interface bba_rsp_if;
    import bba_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [INDEX_OUT_W-1:0] block_index;
    logic [ADDR_W-1:0]      block_address;

    modport source (output valid, status, block_index, block_address, input ready);
    modport sink (input valid, status, block_index, block_address, output ready);
endinterface

interface bba_cfg_if;
    import bba_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/bitmap_block_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator
// Next-fit block allocator over a bitmap held in a word-wide synchronous RAM.
// ----------------------------------------------------------------------------
// Allocate: wrap a stale hint into the pool, scan words from it, then multiply
// and add for the address; a full pool skips both, no active word skips it all.
// Free: the 26-step serial divider, then a map read and write unless outside.
// One request is in flight at a time; the response register frees the request
// side as soon as it is loaded. Reset clears the map through per-word valid
// bits at once, zeroes the hint and restores the register defaults.
module bitmap_block_allocator #(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic         clk,
    input  logic         rst_n,
    bba_cfg_if.sink      cfg,
    bba_req_if.sink      req,
    bba_rsp_if.source    rsp
);
    import bba_pkg::*;

    localparam int MAP_WORDS = (MAX_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int WI_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int WC_W      = $clog2(MAP_WORDS + 1);
    localparam int CNT_W     = $clog2(MAX_BLOCKS + 1);
    localparam int IDX_W     = WI_W + BIT_W;
    localparam int PROD_W    = IDX_W + UNITS_W;

    bba_state_t state_reg;
    bba_state_t state_next;

    logic [COUNT_W-1:0] block_count_reg;
    logic [SIZE_W-1:0]  block_size_reg;
    logic [ADDR_W-1:0]  base_address_reg;

    logic [MAP_WORD_BITS-1:0] map_mem [MAP_WORDS];
    logic [MAP_WORDS-1:0]     map_valid_reg;
    logic [MAP_WORD_BITS-1:0] mem_rdata_reg;
    logic                     rd_valid_reg;

    logic [WI_W-1:0]     hint_reg;
    logic [WI_W-1:0]     cur_reg;
    logic [WC_W-1:0]     scan_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [STATUS_W-1:0] status_reg;

    logic                   rsp_valid_reg;
    logic [STATUS_W-1:0]    rsp_status_reg;
    logic [INDEX_OUT_W-1:0] rsp_index_reg;
    logic [ADDR_W-1:0]      rsp_address_reg;

    logic [CNT_W-1:0]         cnt_eff;
    logic [WC_W-1:0]          words;
    logic [UNITS_W-1:0]       units;
    logic [WC_W-1:0]          cur_ext;
    logic                     wrap_more;
    logic                     scan_last;
    logic [WI_W-1:0]          cur_step;
    logic [MAP_WORD_BITS-1:0] rd_word;
    logic [MAP_WORD_BITS-1:0] seen_word;
    logic                     word_full;
    logic [MAP_WORD_BITS-1:0] clear_onehot;
    logic [BIT_W-1:0]         low_bit;
    logic [31:0]              first_bit;
    logic [31:0]              bits_left;
    logic [MAP_WORD_BITS-1:0] tail_mask;
    logic [ADDR_W-1:0]        offset;
    logic [31:0]              idx_wide;

    logic                     accept;
    logic                     out_free;
    logic                     out_load;
    logic                     mem_re;
    logic                     mem_we;
    logic [MAP_WORD_BITS-1:0] mem_wdata;
    logic                     div_start;
    logic                     div_done;
    logic [OFFSET_W-1:0]      div_quot;
    logic                     free_outside;

    // Effective pool geometry from the configuration registers.
    always_comb
    begin
        if (32'(block_count_reg) > 32'(MAX_BLOCKS))
        begin
            cnt_eff = CNT_W'(MAX_BLOCKS);
        end
        else
        begin
            cnt_eff = CNT_W'(block_count_reg);
        end
        words = WC_W'((32'(cnt_eff) + 32'(MAP_WORD_BITS - 1)) >> BIT_W);
        if (block_size_reg == '0)
        begin
            units = UNITS_W'(1);
        end
        else
        begin
            units = UNITS_W'((18'(block_size_reg) + 18'(MAP_WORD_BITS - 1)) >> BIT_W);
        end
    end

    always_comb
    begin
        cur_ext   = WC_W'(cur_reg);
        wrap_more = cur_ext >= words;
        scan_last = (scan_reg + 1'b1) == words;
        cur_step  = ((cur_ext + 1'b1) == words) ? '0 : WI_W'(cur_ext + 1'b1);
        offset    = req.free_address - base_address_reg;
        idx_wide  = 32'(idx_reg);
        free_outside = 32'(div_quot) >= 32'(cnt_eff);
    end

    // Map word as the search sees it: blocks past the count read as used.
    always_comb
    begin
        rd_word   = rd_valid_reg ? mem_rdata_reg : '0;
        first_bit = 32'({cur_reg, BIT_W'(0)});
        bits_left = 32'(cnt_eff) - first_bit;
        tail_mask = ~((64'd1 << bits_left[BIT_W-1:0]) - 64'd1);
        if (32'(cnt_eff) <= first_bit)
        begin
            seen_word = '1;
        end
        else if (bits_left >= 32'(MAP_WORD_BITS))
        begin
            seen_word = rd_word;
        end
        else
        begin
            seen_word = rd_word | tail_mask;
        end
        word_full    = seen_word == '1;
        clear_onehot = ~seen_word & (seen_word + 64'd1);
    end

    always_comb
    begin
        low_bit = '0;
        for (int i = 0; i < MAP_WORD_BITS; i++)
        begin
            if (clear_onehot[i])
            begin
                low_bit = low_bit | BIT_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.op == OP_FREE)
                    begin
                        state_next = ST_DIV;
                    end
                    else if (words == '0)
                    begin
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        state_next = ST_WRAP;
                    end
                end
            end
            ST_WRAP:
            begin
                if (!wrap_more)
                begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_EVAL;
            end
            ST_SCAN_EVAL:
            begin
                if (!word_full)
                begin
                    state_next = ST_MUL;
                end
                else if (scan_last)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_MUL:
            begin
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                state_next = ST_RESULT;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = free_outside ? ST_RESULT : ST_FREE_RD;
                end
            end
            ST_FREE_RD:
            begin
                state_next = ST_FREE_WR;
            end
            ST_FREE_WR:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req.ready = 1'b0;
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        mem_wdata = rd_word;
        div_start = 1'b0;
        out_load  = 1'b0;
        out_free  = !rsp_valid_reg || rsp.ready;
        case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                div_start = req.valid && (req.op == OP_FREE);
            end
            ST_SCAN_RD, ST_FREE_RD:
            begin
                mem_re = 1'b1;
            end
            ST_SCAN_EVAL:
            begin
                mem_we    = !word_full;
                mem_wdata = rd_word | clear_onehot;
            end
            ST_FREE_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = rd_word & ~(64'd1 << idx_reg[BIT_W-1:0]);
            end
            ST_RESULT:
            begin
                out_load = out_free;
            end
            default:
            begin
                mem_re = 1'b0;
            end
        endcase
        accept = req.valid && req.ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg  <= BLOCK_COUNT_RESET;
            block_size_reg   <= BLOCK_SIZE_RESET;
            base_address_reg <= BASE_ADDRESS_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_BLOCK_COUNT:  block_count_reg  <= cfg.data[COUNT_W-1:0];
                REG_BLOCK_SIZE:   block_size_reg   <= cfg.data[SIZE_W-1:0];
                REG_BASE_ADDRESS: base_address_reg <= cfg.data[ADDR_W-1:0];
                default:          block_count_reg  <= block_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[cur_reg] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= map_mem[cur_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
            hint_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                map_valid_reg[cur_reg] <= 1'b1;
                hint_reg               <= cur_reg;
            end
            if (mem_re)
            begin
                rd_valid_reg <= map_valid_reg[cur_reg];
            end
            if (out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cur_reg  <= hint_reg;
                    idx_reg  <= '0;
                    addr_reg <= '0;
                    if (req.op == OP_ALLOC && words == '0)
                    begin
                        status_reg <= STATUS_FULL;
                    end
                    else
                    begin
                        status_reg <= STATUS_OK;
                    end
                end
            end
            ST_WRAP:
            begin
                scan_reg <= '0;
                if (wrap_more)
                begin
                    cur_reg <= WI_W'(cur_ext - words);
                end
            end
            ST_SCAN_EVAL:
            begin
                if (!word_full)
                begin
                    idx_reg <= {cur_reg, low_bit};
                end
                else if (scan_last)
                begin
                    status_reg <= STATUS_FULL;
                end
                else
                begin
                    cur_reg  <= cur_step;
                    scan_reg <= scan_reg + 1'b1;
                end
            end
            ST_MUL:
            begin
                prod_reg <= PROD_W'(idx_reg) * PROD_W'(units);
            end
            ST_ADD:
            begin
                addr_reg <= base_address_reg + ADDR_W'({prod_reg, BIT_W'(0)});
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (free_outside)
                    begin
                        status_reg <= STATUS_OUTSIDE;
                    end
                    else
                    begin
                        idx_reg <= div_quot[IDX_W-1:0];
                        cur_reg <= div_quot[BIT_W +: WI_W];
                    end
                end
            end
            ST_RESULT:
            begin
                if (out_load)
                begin
                    rsp_status_reg  <= status_reg;
                    rsp_index_reg   <= idx_wide[INDEX_OUT_W-1:0];
                    rsp_address_reg <= addr_reg;
                end
            end
            default:
            begin
                addr_reg <= addr_reg;
            end
        endcase
    end

    bba_divider #(
        .DIVIDEND_W (OFFSET_W),
        .DIVISOR_W  (UNITS_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (offset[ADDR_W-1:BIT_W]),
        .divisor  (units),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign cfg.ready         = 1'b1;
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = rsp_status_reg;
    assign rsp.block_index   = rsp_index_reg;
    assign rsp.block_address = rsp_address_reg;

    a_write_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (WC_W'(cur_reg) < words))
        else $error("map write outside the active word range");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != STATUS_OK) |->
            (rsp.block_index == '0 && rsp.block_address == '0))
        else $error("failed response carries a nonzero index or address");

    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside a free request");

endmodule

@@ hw/rtl/bba_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bba_divider #(
    parameter int DIVIDEND_W = 26,
    parameter int DIVISOR_W  = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);
    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [DIVIDEND_W-1:0] quot_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  divisor_reg;

    logic [DIVISOR_W:0]    rem_shift;
    logic                  fits;
    logic [DIVISOR_W-1:0]  rem_next;
    logic [DIVIDEND_W-1:0] quot_next;

    always_comb
    begin
        rem_shift = {rem_reg, quot_reg[DIVIDEND_W-1]};
        fits      = rem_shift >= {1'b0, divisor_reg};
        rem_next  = fits ? DIVISOR_W'(rem_shift - {1'b0, divisor_reg})
                         : DIVISOR_W'(rem_shift);
        quot_next = {quot_reg[DIVIDEND_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_W'(DIVIDEND_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg    <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

@@ tb/bitmap_block_allocator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap block allocator testbench
// Drives allocate and free requests through the request channel and rewrites
// the pool registers between phases. Every request is run through a bitmap
// model kept in the bench, and each response is compared field by field with
// the oldest outcome still due. A directed part covers the pool edges; mixed
// traffic under several idle and stall profiles follows.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_tb;
    import bba_pkg::*;

    localparam int MAX_BLOCKS   = 1024;
    localparam int MAP_WORDS    = MAX_BLOCKS / MAP_WORD_BITS;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 64;
    localparam int REPORT_LIMIT = 10;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [INDEX_OUT_W-1:0] block_index;
        logic [ADDR_W-1:0]      block_address;
    } outcome_t;

    logic clk;
    logic rst_n;

    bba_cfg_if cfg ();
    bba_req_if req ();
    bba_rsp_if rsp ();

    bitmap_block_allocator #(
        .MAX_BLOCKS(MAX_BLOCKS)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .rsp   (rsp)
    );

    logic [MAP_WORD_BITS-1:0] block_map [MAP_WORDS];
    logic [3:0]               search_word;
    logic [COUNT_W-1:0]       count_reg;
    logic [SIZE_W-1:0]        size_reg;
    logic [ADDR_W-1:0]        base_reg;

    outcome_t outcomes_due [$];
    int       mismatch_count;
    int       send_idle_pct;
    int       sink_stall_pct;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int unsigned live_count();
        return (count_reg > MAX_BLOCKS) ? MAX_BLOCKS : count_reg;
    endfunction

    function automatic logic [63:0] block_bytes();
        logic [63:0] s;
        s = 64'(size_reg);
        if (s < 16)
            s = 16;
        return ((s + 63) / 64) * 64;
    endfunction

    // Map word as the search sees it: blocks past the count read as taken.
    function automatic logic [MAP_WORD_BITS-1:0] visible_word(input int unsigned w,
                                                              input int unsigned cnt);
        int unsigned first;
        int unsigned tail;
        first = w * MAP_WORD_BITS;
        if (cnt <= first)
            return '1;
        tail = cnt - first;
        if (tail >= MAP_WORD_BITS)
            return block_map[w];
        return block_map[w] | ~((64'd1 << tail) - 64'd1);
    endfunction

    function automatic outcome_t allocator_outcome(input logic op,
                                                   input logic [ADDR_W-1:0] address);
        outcome_t          r;
        int unsigned       cnt;
        int unsigned       words;
        int unsigned       start;
        int unsigned       w;
        int unsigned       b;
        int unsigned       p;
        logic [63:0]       bytes;
        logic [63:0]       slot;
        logic [ADDR_W-1:0] offset;
        logic [63:0]       word;
        bit                found;
        r = '0;
        found = 1'b0;
        cnt = live_count();
        words = (cnt + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
        bytes = block_bytes();
        if (op == OP_ALLOC)
        begin
            start = (words != 0) ? search_word % words : 0;
            for (p = 0; p < words && !found; p++)
            begin
                w = (start + p) % words;
                word = visible_word(w, cnt);
                if (word != '1)
                begin
                    b = 0;
                    while (b < 63 && word[b])
                        b++;
                    block_map[w][b] = 1'b1;
                    search_word = 4'(w);
                    slot = 64'(w * MAP_WORD_BITS + b);
                    r.block_index = slot[INDEX_OUT_W-1:0];
                    r.block_address = ADDR_W'(base_reg + slot * bytes);
                    found = 1'b1;
                end
            end
            if (!found)
                r.status = STATUS_FULL;
        end
        else
        begin
            offset = address - base_reg;
            slot = 64'(offset);
            slot = slot / bytes;
            if (slot >= cnt)
                r.status = STATUS_OUTSIDE;
            else
            begin
                block_map[slot[9:6]][slot[5:0]] = 1'b0;
                search_word = slot[9:6];
                r.block_index = slot[INDEX_OUT_W-1:0];
            end
        end
        return r;
    endfunction

    // Mostly picks a block that is currently taken, so frees do real work.
    function automatic logic [ADDR_W-1:0] owned_block_address(input bit unaligned);
        int unsigned cnt;
        int unsigned t;
        logic [63:0] bytes;
        logic [63:0] slot;
        logic [31:0] span;
        cnt = live_count();
        bytes = block_bytes();
        span = bytes[31:0];
        if (cnt == 0)
            return $urandom;
        slot = 64'($urandom_range(0, cnt - 1));
        for (t = 0; t < 8 && !block_map[slot[9:6]][slot[5:0]]; t++)
            slot = 64'($urandom_range(0, cnt - 1));
        return ADDR_W'(base_reg + slot * bytes +
                       (unaligned ? 64'($urandom_range(0, span - 1)) : 64'd0));
    endfunction

    task automatic send_request(input logic op, input logic [ADDR_W-1:0] address);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct)
                @(posedge clk);
        end
        req.valid <= 1'b1;
        req.op <= op;
        req.free_address <= address;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        outcomes_due.push_back(allocator_outcome(op, address));
    endtask

    task automatic finish_requests();
        req.valid <= 1'b0;
        @(posedge clk);
        while (outcomes_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] count_data,
                             input logic [CFG_DATA_W-1:0] size_data,
                             input logic [CFG_DATA_W-1:0] base_data,
                             input bit                    poke_spare);
        logic [CFG_INDEX_W-1:0] index [4];
        logic [CFG_DATA_W-1:0]  value [4];
        int                     n;
        int                     k;
        index[0] = REG_BLOCK_COUNT;
        value[0] = count_data;
        index[1] = REG_BLOCK_SIZE;
        value[1] = size_data;
        index[2] = REG_BASE_ADDRESS;
        value[2] = base_data;
        index[3] = REG_SPARE;
        value[3] = $urandom;
        n = poke_spare ? 4 : 3;
        for (k = 0; k < n; k++)
        begin
            cfg.valid <= 1'b1;
            cfg.index <= index[k];
            cfg.data <= value[k];
            @(posedge clk);
            while (!cfg.ready)
                @(posedge clk);
            case (index[k])
                REG_BLOCK_COUNT:  count_reg = value[k][COUNT_W-1:0];
                REG_BLOCK_SIZE:   size_reg = value[k][SIZE_W-1:0];
                REG_BASE_ADDRESS: base_reg = value[k];
                default: ;
            endcase
        end
        cfg.valid <= 1'b0;
    endtask

    task automatic run_mixed_traffic(input int items);
        int unsigned roll;
        int          k;
        for (k = 0; k < items; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 55)
                send_request(OP_ALLOC, $urandom);
            else if (roll < 85)
                send_request(OP_FREE, owned_block_address(1'($urandom_range(0, 1))));
            else if (roll < 93)
                send_request(OP_FREE, $urandom);
            else
                send_request(OP_FREE,
                             ADDR_W'(base_reg + live_count() * block_bytes() +
                                     64'($urandom_range(0, 4095))));
        end
        finish_requests();
    endtask

    task automatic test_default_pool();
        send_request(OP_ALLOC, 32'h0);
        send_request(OP_ALLOC, 32'hFFFF_FFFF);
        send_request(OP_FREE, 32'd69);
        send_request(OP_FREE, 32'd64);
        send_request(OP_ALLOC, 32'h0);
        send_request(OP_FREE, 32'h0001_0000);
        send_request(OP_FREE, 32'hFFFF_FFFF);
        send_request(OP_FREE, 32'h0000_FFFF);
        send_request(OP_ALLOC, 32'h0);
        finish_requests();
    endtask

    // One odd-sized block whose base sits just below the top of the address space.
    task automatic test_wrapped_pool();
        configure(32'd1, 32'd100, 32'hFFFF_FFC0, 1'b0);
        send_request(OP_FREE, 32'hFFFF_FFC0);
        send_request(OP_ALLOC, 32'h0);
        send_request(OP_ALLOC, 32'h0);
        send_request(OP_FREE, 32'h0000_0040);
        send_request(OP_FREE, 32'h0000_0000);
        finish_requests();
    endtask

    task automatic test_edge_counts();
        configure(32'd0, 32'd0, 32'd0, 1'b1);
        send_request(OP_ALLOC, 32'h0);
        send_request(OP_FREE, 32'h0);
        finish_requests();
        configure(32'd2047, 32'd131071, 32'h8000_0000, 1'b0);
        send_request(OP_FREE, 32'h87D0_0000);
        send_request(OP_ALLOC, 32'h0);
        finish_requests();
        // The hint now points past the single word left by the smaller count.
        configure(32'd64, 32'd64, 32'd0, 1'b0);
        send_request(OP_ALLOC, 32'h0);
        send_request(OP_FREE, 32'h0000_1000);
        finish_requests();
    endtask

    task automatic test_traffic_no_idle();
        send_idle_pct = 0;
        sink_stall_pct = 0;
        configure(($urandom & 32'hFFFF_F800) | 32'd150, 32'd64 * $urandom_range(1, 4),
                  $urandom, 1'b1);
        run_mixed_traffic(150);
    endtask

    task automatic test_traffic_sender_idle();
        send_idle_pct = 70;
        sink_stall_pct = 0;
        configure(32'd2047, ($urandom & 32'hFFFE_0000) | 32'd131071, $urandom, 1'b0);
        run_mixed_traffic(130);
    endtask

    task automatic test_traffic_sink_stall();
        send_idle_pct = 0;
        sink_stall_pct = 70;
        configure(32'd40, $urandom_range(0, 131071), $urandom, 1'b0);
        run_mixed_traffic(140);
    endtask

    task automatic test_traffic_both_idle();
        send_idle_pct = 18;
        sink_stall_pct = 18;
        configure($urandom_range(65, 1024), $urandom_range(0, 2047), $urandom, 1'b0);
        run_mixed_traffic(140);
    endtask

    always @(posedge clk)
    begin : response_check
        outcome_t want;
        rsp.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (outcomes_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("Unexpected response: status %0d index %0d address %h",
                             rsp.status, rsp.block_index, rsp.block_address);
            end
            else
            begin
                want = outcomes_due.pop_front();
                if (rsp.status !== want.status || rsp.block_index !== want.block_index ||
                    rsp.block_address !== want.block_address)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"Response mismatch: status %0d got %0d, index %0d got %0d,",
                                  " address %h got %h"},
                                 want.status, rsp.status, want.block_index, rsp.block_index,
                                 want.block_address, rsp.block_address);
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
                (cfg.valid && cfg.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        for (int w = 0; w < MAP_WORDS; w++)
            block_map[w] = '0;
        search_word = '0;
        count_reg = BLOCK_COUNT_RESET;
        size_reg = BLOCK_SIZE_RESET;
        base_reg = BASE_ADDRESS_RESET;
        mismatch_count = 0;
        send_idle_pct = 0;
        sink_stall_pct = 0;
        rst_n <= 1'b0;
        req.valid <= 1'b0;
        req.op <= OP_ALLOC;
        req.free_address <= '0;
        cfg.valid <= 1'b0;
        cfg.index <= REG_BLOCK_COUNT;
        cfg.data <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_default_pool();
        test_wrapped_pool();
        test_edge_counts();
        test_traffic_no_idle();
        test_traffic_sender_idle();
        test_traffic_sink_stall();
        test_traffic_both_idle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && outcomes_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/bba_pkg.sv
hw/rtl/bba_if.sv
hw/rtl/bba_divider.sv
hw/rtl/bitmap_block_allocator.sv
tb/bitmap_block_allocator_tb.sv
